### hw/rtl/lcbs_pkg.sv
`default_nettype none
package lcbs_pkg;

	localparam int MAX_DIM = 4096;
	localparam int POS_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = POS_W + 1;
	localparam int AREA_W  = 2 * POS_W + 1;
	localparam int CONF_W  = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [CONF_W-1:0] MIN_CONF_RST = CONF_W'(19660);
	localparam logic [DIM_W-1:0]  IMG_W_RST    = DIM_W'(1280);
	localparam logic [DIM_W-1:0]  IMG_H_RST    = DIM_W'(720);

	typedef enum logic [1:0] {
		CMD_BOX     = 2'd0,
		CMD_BOX_EOF = 2'd1,
		CMD_EOF     = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_CONF = 2'd0,
		REG_IMG_W    = 2'd1,
		REG_IMG_H    = 2'd2,
		REG_UNUSED   = 2'd3
	} reg_idx_t;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic             has_box;
		logic             eof;
		logic [POS_W-1:0] left;
		logic [POS_W-1:0] top;
		logic [DIM_W-1:0] wide;
		logic [DIM_W-1:0] tall;
	} entry_t;

endpackage
`default_nettype wire

### hw/rtl/lcbs_front.sv
`default_nettype none
module lcbs_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lcbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcbs_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       cmd,
	input  logic                             is_wanted_class,
	input  logic [lcbs_pkg::CONF_W-1:0]      confidence,
	input  logic signed [lcbs_pkg::DIM_W-1:0] box_x,
	input  logic signed [lcbs_pkg::DIM_W-1:0] box_y,
	input  logic signed [lcbs_pkg::DIM_W-1:0] box_w,
	input  logic signed [lcbs_pkg::DIM_W-1:0] box_h,
	input  logic                             q_full,
	output logic                             push,
	output lcbs_pkg::entry_t                 entry
);
	import lcbs_pkg::*;

	logic [CONF_W-1:0] min_conf_q;
	logic [DIM_W-1:0]  img_w_q;
	logic [DIM_W-1:0]  img_h_q;

	logic [POS_W-1:0]       lim_x, lim_y;
	logic signed [DIM_W:0]  x1, y1;
	logic                   out_x, out_y, empty, conf_ok, is_box, is_eof, box_ok;
	logic [POS_W-1:0]       x0c, y0c, x1c, y1c;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_conf_q <= MIN_CONF_RST;
			img_w_q    <= IMG_W_RST;
			img_h_q    <= IMG_H_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MIN_CONF: min_conf_q <= cfg_data[CONF_W-1:0];
				REG_IMG_W:    img_w_q    <= cfg_data[DIM_W-1:0];
				REG_IMG_H:    img_h_q    <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [POS_W-1:0] last_index(input logic [DIM_W-1:0] dim);
		logic [DIM_W-1:0] m1;
		m1 = dim - DIM_W'(1);
		if (dim == '0)
			return '0;
		else if (dim > DIM_W'(MAX_DIM))
			return POS_W'(MAX_DIM - 1);
		else
			return m1[POS_W-1:0];
	endfunction

	always_comb begin
		lim_x = last_index(img_w_q);
		lim_y = last_index(img_h_q);
		x1 = $signed({box_x[DIM_W-1], box_x}) + $signed({box_w[DIM_W-1], box_w})
			- $signed((DIM_W+1)'(1));
		y1 = $signed({box_y[DIM_W-1], box_y}) + $signed({box_h[DIM_W-1], box_h})
			- $signed((DIM_W+1)'(1));
		out_x = x1[DIM_W] || (box_x > $signed({1'b0, lim_x}));
		out_y = y1[DIM_W] || (box_y > $signed({1'b0, lim_y}));
		empty = box_w[DIM_W-1] || (box_w == '0)
			|| box_h[DIM_W-1] || (box_h == '0);
		conf_ok = confidence > min_conf_q;

		// clip to the image
		x0c = box_x[DIM_W-1] ? '0 : box_x[POS_W-1:0];
		y0c = box_y[DIM_W-1] ? '0 : box_y[POS_W-1:0];
		x1c = (x1 > $signed({2'b00, lim_x})) ? lim_x : x1[POS_W-1:0];
		y1c = (y1 > $signed({2'b00, lim_y})) ? lim_y : y1[POS_W-1:0];

		is_box = 1'b0;
		is_eof = 1'b0;
		case (cmd_t'(cmd))
			CMD_BOX:     is_box = 1'b1;
			CMD_BOX_EOF: begin
				is_box = 1'b1;
				is_eof = 1'b1;
			end
			CMD_EOF:     is_eof = 1'b1;
			default: ;
		endcase
		box_ok = is_box && is_wanted_class && conf_ok && !empty && !out_x && !out_y;

		entry.has_box = box_ok;
		entry.eof     = is_eof;
		entry.left    = x0c;
		entry.top     = y0c;
		entry.wide    = {1'b0, x1c} - {1'b0, x0c} + DIM_W'(1);
		entry.tall    = {1'b0, y1c} - {1'b0, y0c} + DIM_W'(1);
	end

	// Drop items that neither carry a qualifying box nor end a frame.
	assign in_ready = !q_full;
	assign push     = in_valid && in_ready && (box_ok || is_eof);

endmodule
`default_nettype wire

### hw/rtl/lcbs_queue.sv
`default_nettype none
module lcbs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lcbs_pkg::entry_t wr_entry,
	input  logic             pop,
	output logic             q_valid,
	output logic             q_full,
	output lcbs_pkg::entry_t head,
	output logic [lcbs_pkg::QCNT_W-1:0] count
);
	import lcbs_pkg::*;

	entry_t            mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_valid = cnt_q != '0;
	assign q_full  = cnt_q == QCNT_W'(QDEPTH);
	assign head    = mem[rd_ptr_q];
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lcbs_back.sv
`default_nettype none
module lcbs_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  lcbs_pkg::entry_t             head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [lcbs_pkg::POS_W-1:0]   best_x,
	output logic [lcbs_pkg::POS_W-1:0]   best_y,
	output logic [lcbs_pkg::DIM_W-1:0]   best_width,
	output logic [lcbs_pkg::DIM_W-1:0]   best_height
);
	import lcbs_pkg::*;

	logic              have_best_q;
	logic [AREA_W-1:0] best_area_q;
	logic [POS_W-1:0]  best_left_q, best_top_q;
	logic [DIM_W-1:0]  best_wide_q, best_tall_q;

	logic              out_valid_q, found_q;
	logic [POS_W-1:0]  out_x_q, out_y_q;
	logic [DIM_W-1:0]  out_w_q, out_h_q;

	logic [2*DIM_W-1:0] prod;
	logic [AREA_W-1:0]  area;
	logic               take, out_free;

	assign prod = head.wide * head.tall;
	assign area = prod[AREA_W-1:0];
	assign take = head.has_box && (!have_best_q || area > best_area_q);

	// An end of frame waits until the output register is free.
	assign out_free = !out_valid_q || out_ready;
	assign pop      = q_valid && (!head.eof || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
			best_area_q <= '0;
			best_left_q <= '0;
			best_top_q  <= '0;
			best_wide_q <= '0;
			best_tall_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (pop) begin
				if (head.eof) begin
					out_valid_q <= 1'b1;
					have_best_q <= 1'b0;
					best_area_q <= '0;
					best_left_q <= '0;
					best_top_q  <= '0;
					best_wide_q <= '0;
					best_tall_q <= '0;
				end else if (take) begin
					have_best_q <= 1'b1;
					best_area_q <= area;
					best_left_q <= head.left;
					best_top_q  <= head.top;
					best_wide_q <= head.wide;
					best_tall_q <= head.tall;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.eof) begin
			found_q <= have_best_q || take;
			out_x_q <= take ? head.left : best_left_q;
			out_y_q <= take ? head.top  : best_top_q;
			out_w_q <= take ? head.wide : best_wide_q;
			out_h_q <= take ? head.tall : best_tall_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign best_x      = out_x_q;
	assign best_y      = out_y_q;
	assign best_width  = out_w_q;
	assign best_height = out_h_q;

endmodule
`default_nettype wire

### hw/rtl/largest_clipped_box_select_top.sv
// Largest clipped box selection over the detection boxes of one frame.
// Input channel (in_valid/in_ready): one item per box or frame marker. cmd
// selects box, box followed by end of frame, or end of frame alone; code 3
// is taken and has no effect. A box counts when it is of the wanted class,
// its confidence beats min_confidence, its size is positive and it overlaps
// the image; it is then clipped and the first one with the largest area wins.
// Output channel (out_valid/out_ready): one item per end of frame with the
// best clipped box, or found low and all fields zero; the best then clears.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 min_confidence,
// 1 image width, 2 image height; write only while the block is idle.
// Throughput: one item per cycle while the queue has room. The front classifies
// and clips in the accept cycle and writes the item into the queue; the back
// takes it from the queue head, forms the area with one 13x13 multiply,
// compares against the best and registers the result of an end of frame.
// Reset: registers return to 19660, 1280 and 720, the best is cleared.
// Stall: a held result stops the queue once an end of frame reaches its head;
// items keep entering until the two entries fill, then in_ready drops.
`default_nettype none
module largest_clipped_box_select_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lcbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcbs_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic                              is_wanted_class,
	input  logic [lcbs_pkg::CONF_W-1:0]       confidence,
	input  logic signed [lcbs_pkg::DIM_W-1:0] box_x,
	input  logic signed [lcbs_pkg::DIM_W-1:0] box_y,
	input  logic signed [lcbs_pkg::DIM_W-1:0] box_w,
	input  logic signed [lcbs_pkg::DIM_W-1:0] box_h,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [lcbs_pkg::POS_W-1:0]        best_x,
	output logic [lcbs_pkg::POS_W-1:0]        best_y,
	output logic [lcbs_pkg::DIM_W-1:0]        best_width,
	output logic [lcbs_pkg::DIM_W-1:0]        best_height
);
	import lcbs_pkg::*;

	logic              push, pop, q_valid, q_full;
	entry_t            wr_entry, head;
	logic [QCNT_W-1:0] q_count;

	// Front: config registers, filtering and clipping.
	lcbs_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.is_wanted_class (is_wanted_class),
		.confidence      (confidence),
		.box_x           (box_x),
		.box_y           (box_y),
		.box_w           (box_w),
		.box_h           (box_h),
		.q_full          (q_full),
		.push            (push),
		.entry           (wr_entry)
	);

	// Queue: decouple the front from a stalled output.
	lcbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_full   (q_full),
		.head     (head),
		.count    (q_count)
	);

	// Back: area, best tracking and the result register.
	lcbs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.best_x      (best_x),
		.best_y      (best_y),
		.best_width  (best_width),
		.best_height (best_height)
	);

	// Never push into a full queue or pop an empty one.
	a_queue_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(!push || !q_full) && (!pop || q_valid) && (q_count <= QCNT_W'(QDEPTH)))
		else $error("queue over- or underflow");

	// An empty frame reports all-zero geometry.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> best_x == '0 && best_y == '0
			&& best_width == '0 && best_height == '0)
		else $error("no-box result carries geometry");

	// A found box is nonempty and lies inside the largest image.
	a_found_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> best_width != '0 && best_height != '0
			&& ({1'b0, best_x} + {1'b0, best_width}) <= (DIM_W+1)'(MAX_DIM)
			&& ({1'b0, best_y} + {1'b0, best_height}) <= (DIM_W+1)'(MAX_DIM))
		else $error("best box outside the image bounds");

	// A box can only leave the front while it has room downstream.
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !q_full)
		else $error("item accepted with the queue full");

endmodule
`default_nettype wire

### dv/lcbs_scoreboard_pkg.sv
package lcbs_scoreboard_pkg;

	import lcbs_pkg::*;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
	} crop_t;

	class crop_scoreboard;
		logic [CONF_W-1:0] min_conf;
		logic [DIM_W-1:0]  img_w;
		logic [DIM_W-1:0]  img_h;
		bit                have_best;
		logic [AREA_W-1:0] best_area;
		crop_t             best;
		crop_t             crops_due[$];
		int                errors;

		function new();
			min_conf = MIN_CONF_RST;
			img_w    = IMG_W_RST;
			img_h    = IMG_H_RST;
			errors   = 0;
			clear_best();
		endfunction

		function void clear_best();
			have_best = 1'b0;
			best_area = '0;
			best      = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_MIN_CONF: min_conf = data[CONF_W-1:0];
				REG_IMG_W:    img_w = data[DIM_W-1:0];
				REG_IMG_H:    img_h = data[DIM_W-1:0];
				default: ;
			endcase
		endfunction

		// Zero means one pixel, anything past MAX_DIM saturates.
		function int clamp_dim(logic [DIM_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_DIM)
				return MAX_DIM;
			return int'(v);
		endfunction

		function void fold_box(logic wanted, logic [CONF_W-1:0] conf,
				logic signed [DIM_W-1:0] bx, logic signed [DIM_W-1:0] by,
				logic signed [DIM_W-1:0] bw, logic signed [DIM_W-1:0] bh);
			int x0, y0, x1, y1, w, h, lim_x, lim_y, cw, ch, area;
			if (!wanted || conf <= min_conf)
				return;
			x0 = bx;
			y0 = by;
			w  = bw;
			h  = bh;
			if (w <= 0 || h <= 0)
				return;
			x1 = x0 + w - 1;
			y1 = y0 + h - 1;
			lim_x = clamp_dim(img_w) - 1;
			lim_y = clamp_dim(img_h) - 1;
			if (x1 < 0 || y1 < 0 || x0 > lim_x || y0 > lim_y)
				return;
			if (x0 < 0) x0 = 0;
			if (y0 < 0) y0 = 0;
			if (x1 > lim_x) x1 = lim_x;
			if (y1 > lim_y) y1 = lim_y;
			cw = x1 - x0 + 1;
			ch = y1 - y0 + 1;
			area = cw * ch;
			// strictly larger only: on a tie the earlier box holds
			if (!have_best || area > int'(best_area)) begin
				have_best  = 1'b1;
				best_area  = area[AREA_W-1:0];
				best.found = 1'b1;
				best.x     = x0[POS_W-1:0];
				best.y     = y0[POS_W-1:0];
				best.w     = cw[DIM_W-1:0];
				best.h     = ch[DIM_W-1:0];
			end
		endfunction

		function void note_item(cmd_t op, logic wanted, logic [CONF_W-1:0] conf,
				logic signed [DIM_W-1:0] bx, logic signed [DIM_W-1:0] by,
				logic signed [DIM_W-1:0] bw, logic signed [DIM_W-1:0] bh);
			if (op == CMD_NONE)
				return;
			if (op != CMD_EOF)
				fold_box(wanted, conf, bx, by, bw, bh);
			if (op == CMD_BOX)
				return;
			crops_due.push_back(best);
			clear_best();
		endfunction

		function void check_result(crop_t got);
			crop_t want;
			if (crops_due.size() == 0) begin
				$error("result with no frame end pending: found %0d x %0d y %0d w %0d h %0d",
					got.found, got.x, got.y, got.w, got.h);
				errors++;
				return;
			end
			want = crops_due.pop_front();
			if (got.found !== want.found) begin
				$error("found mismatch: expected %0d, actual %0d", want.found, got.found);
				errors++;
			end
			if (got.x !== want.x) begin
				$error("best_x mismatch: expected %0d, actual %0d", want.x, got.x);
				errors++;
			end
			if (got.y !== want.y) begin
				$error("best_y mismatch: expected %0d, actual %0d", want.y, got.y);
				errors++;
			end
			if (got.w !== want.w) begin
				$error("best_width mismatch: expected %0d, actual %0d", want.w, got.w);
				errors++;
			end
			if (got.h !== want.h) begin
				$error("best_height mismatch: expected %0d, actual %0d", want.h, got.h);
				errors++;
			end
		endfunction

		function int pending();
			return crops_due.size();
		endfunction
	endclass

endpackage

### dv/tb_largest_clipped_box_select_top.sv
module tb_largest_clipped_box_select_top;

	import lcbs_pkg::*;
	import lcbs_scoreboard_pkg::*;

	// One detection item as the driver presents it.
	typedef struct {
		cmd_t                    op;
		logic                    wanted;
		logic [CONF_W-1:0]       conf;
		logic signed [DIM_W-1:0] x;
		logic signed [DIM_W-1:0] y;
		logic signed [DIM_W-1:0] w;
		logic signed [DIM_W-1:0] h;
	} det_item_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [1:0]              cmd;
	logic                    is_wanted_class;
	logic [CONF_W-1:0]       confidence;
	logic signed [DIM_W-1:0] box_x;
	logic signed [DIM_W-1:0] box_y;
	logic signed [DIM_W-1:0] box_w;
	logic signed [DIM_W-1:0] box_h;
	logic                    out_valid;
	logic                    out_ready;
	logic                    found;
	logic [POS_W-1:0]        best_x;
	logic [POS_W-1:0]        best_y;
	logic [DIM_W-1:0]        best_width;
	logic [DIM_W-1:0]        best_height;

	crop_scoreboard sb;

	// Current setting as seen by the stimulus, used to aim boxes at the image.
	logic [CONF_W-1:0] thr;
	int                dim_x;
	int                dim_y;
	// When set, neither side idles: back-to-back items and results.
	bit                no_gaps;

	largest_clipped_box_select_top u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.is_wanted_class (is_wanted_class),
		.confidence      (confidence),
		.box_x           (box_x),
		.box_y           (box_y),
		.box_w           (box_w),
		.box_h           (box_h),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.best_x          (best_x),
		.best_y          (best_y),
		.best_width      (best_width),
		.best_height     (best_height)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic det_item_t mk(cmd_t op, logic wanted, int conf, int x, int y,
			int w, int h);
		det_item_t it;
		it.op     = op;
		it.wanted = wanted;
		it.conf   = CONF_W'(conf);
		it.x      = DIM_W'(x);
		it.y      = DIM_W'(y);
		it.w      = DIM_W'(w);
		it.h      = DIM_W'(h);
		return it;
	endfunction

	// Mostly well-formed boxes near the image with small sizes, so ties and
	// replacements of the best happen often; the rest is pure noise.
	function automatic det_item_t rand_box(cmd_t op);
		det_item_t it;
		bit        big;
		it.op = op;
		if ($urandom_range(0, 99) < 80) begin
			big       = ($urandom_range(0, 15) == 0);
			it.wanted = 1'b1;
			if (thr >= CONF_W'(32768))
				it.conf = CONF_W'($urandom);
			else
				it.conf = CONF_W'($urandom_range(32'(thr) + 1, 32768));
			it.w = DIM_W'(big ? $urandom_range(1, 4095) : $urandom_range(1, 24));
			it.h = DIM_W'(big ? $urandom_range(1, 4095) : $urandom_range(1, 24));
			it.x = DIM_W'(int'($urandom_range(0, dim_x + 15)) - 16);
			it.y = DIM_W'(int'($urandom_range(0, dim_y + 15)) - 16);
		end else begin
			it.wanted = 1'($urandom);
			it.conf   = CONF_W'($urandom);
			it.x      = DIM_W'($urandom);
			it.y      = DIM_W'($urandom);
			it.w      = DIM_W'($urandom);
			it.h      = DIM_W'($urandom);
		end
		return it;
	endfunction

	// Present one item, hold it until taken, note it, then maybe idle.
	task automatic push_item(det_item_t it);
		int gap;
		cmd             <= it.op;
		is_wanted_class <= it.wanted;
		confidence      <= it.conf;
		box_x           <= it.x;
		box_y           <= it.y;
		box_w           <= it.w;
		box_h           <= it.h;
		in_valid        <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(it.op, it.wanted, it.conf, it.x, it.y, it.w, it.h);
		gap = pick_gap();
		// keep valid high across back-to-back items; drop it only for a gap
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Write all registers, the unused index too, then track the new setting.
	task automatic apply_config(logic [CFG_W-1:0] conf_thr, logic [CFG_W-1:0] width,
			logic [CFG_W-1:0] height);
		reg_idx_t         order[4];
		logic [CFG_W-1:0] vals[4];
		int               wv;
		int               hv;
		order = '{REG_MIN_CONF, REG_IMG_W, REG_IMG_H, REG_UNUSED};
		vals  = '{conf_thr, width, height, CFG_W'($urandom)};
		for (int i = 0; i < 4; i++) begin
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg_ready);
			sb.set_reg(order[i], vals[i]);
		end
		cfg_valid <= 1'b0;
		thr   = conf_thr[CONF_W-1:0];
		wv    = width[DIM_W-1:0];
		hv    = height[DIM_W-1:0];
		dim_x = (wv == 0) ? 1 : ((wv > MAX_DIM) ? MAX_DIM : wv);
		dim_y = (hv == 0) ? 1 : ((hv > MAX_DIM) ? MAX_DIM : hv);
	endtask

	// Drop valid, wait for every pending frame result, then let the front, queue
	// and back empty of trailing boxes that produce no result.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Whole frames: a run of boxes closed by an end marker, with a stray
	// unused command now and then.
	task automatic run_frames(int n_items);
		int sent;
		int n_boxes;
		sent = 0;
		while (sent < n_items) begin
			no_gaps = ($urandom_range(0, 7) == 0);
			n_boxes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
			                                     : $urandom_range(0, 6);
			for (int i = 0; i < n_boxes; i++) begin
				if ($urandom_range(0, 49) == 0) begin
					push_item(rand_box(CMD_NONE));
					sent++;
				end
				push_item(rand_box(CMD_BOX));
				sent++;
			end
			push_item(rand_box(($urandom_range(0, 1) == 0) ? CMD_BOX_EOF : CMD_EOF));
			sent++;
		end
		no_gaps = 1'b0;
	endtask

	// Result side: check every accepted result, stall out_ready at random.
	initial begin
		int stall;
		stall     = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(crop_t'{found, best_x, best_y, best_width, best_height});
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		sb              = new();
		no_gaps         = 1'b0;
		thr             = MIN_CONF_RST;
		dim_x           = int'(IMG_W_RST);
		dim_y           = int'(IMG_H_RST);
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = REG_MIN_CONF;
		cfg_data        = '0;
		in_valid        = 1'b0;
		cmd             = CMD_NONE;
		is_wanted_class = 1'b0;
		confidence      = '0;
		box_x           = '0;
		box_y           = '0;
		box_w           = '0;
		box_h           = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset setting of 1280x720 and 0.6.
		// empty frame
		push_item(mk(CMD_EOF, 1'b0, 0, 0, 0, 0, 0));
		// each rejection: wrong class, confidence at threshold, zero width,
		// negative height, wholly left, right, below and above the image
		push_item(mk(CMD_BOX, 1'b0, 32768, 10, 10, 50, 50));
		push_item(mk(CMD_BOX, 1'b1, 19660, 10, 10, 50, 50));
		push_item(mk(CMD_BOX, 1'b1, 65535, 10, 10, 0, 50));
		push_item(mk(CMD_BOX, 1'b1, 32768, 10, 10, 50, -4096));
		push_item(mk(CMD_BOX, 1'b1, 32768, -100, 10, 100, 50));
		push_item(mk(CMD_BOX, 1'b1, 32768, 1280, 10, 5, 5));
		push_item(mk(CMD_BOX, 1'b1, 32768, 10, 720, 5, 5));
		push_item(mk(CMD_BOX, 1'b1, 32768, 10, -60, 5, 60));
		push_item(mk(CMD_BOX_EOF, 1'b1, 19661, 4095, 4095, 4095, 4095));
		// box clipped on every side, an ignored unused command, then a tiny box
		push_item(mk(CMD_BOX, 1'b1, 19661, -10, -10, 4095, 4095));
		push_item(mk(CMD_NONE, 1'b1, 32768, 0, 0, 4095, 4095));
		push_item(mk(CMD_BOX_EOF, 1'b1, 32768, 1279, 719, 1, 1));
		// three boxes of equal clipped area: the first one must win
		push_item(mk(CMD_BOX, 1'b1, 20000, 0, 0, 10, 10));
		push_item(mk(CMD_BOX, 1'b1, 20000, 100, 100, 20, 5));
		push_item(mk(CMD_BOX, 1'b1, 20000, -4000, 0, 4050, 2));
		push_item(mk(CMD_EOF, 1'b1, 32768, 0, 0, 0, 0));
		// bottom-right corner pixel, then most negative corner wholly outside
		push_item(mk(CMD_BOX_EOF, 1'b1, 32768, 1279, 719, 4095, 4095));
		push_item(mk(CMD_BOX_EOF, 1'b1, 32768, -4096, -4096, 4095, 4095));
		settle();

		// Extremes of the registers, including zero and saturating sizes and
		// data bits above the register width.
		apply_config(16'd0, 16'd4096, 16'd4096);
		run_frames(150);
		settle();
		apply_config(16'd32768, 16'h2000, 16'd8191);
		run_frames(100);
		settle();
		apply_config(16'hFFFF, 16'd1, 16'd1);
		run_frames(50);
		settle();
		apply_config(16'd1, 16'hFFFF, 16'd0);
		run_frames(60);
		settle();
		apply_config(MIN_CONF_RST, IMG_W_RST, IMG_H_RST);
		run_frames(120);
		settle();

		// Random settings across the legal range.
		repeat (6) begin
			apply_config(CFG_W'($urandom_range(0, 32768)), CFG_W'($urandom_range(1, 4096)),
				CFG_W'($urandom_range(1, 4096)));
			run_frames(110);
			settle();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
